// ===== sv/dq_pkg.sv =====
// dq_pkg: shared types, constants and ring-index helpers for the deque
// no dependencies; imported by the channel interfaces, the controller and the top level

package dq_pkg;

  // storage geometry
  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // field widths fixed by the channel format
  localparam int CMD_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // controller states
  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  // request from the controller to the element store
  typedef struct packed {
    logic              we;
    logic [PTR_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [PTR_W-1:0]  raddr;
  } ram_req_t;

  // (ptr + off) mod DEPTH, with ptr < DEPTH and off <= DEPTH
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] ptr,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  // step one entry back around the ring
  function automatic logic [PTR_W-1:0] ring_dec(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == '0) begin
      res = PTR_W'(DEPTH - 1);
    end else begin
      res = ptr - PTR_W'(1);
    end
    return res;
  endfunction

  // step one entry forward around the ring
  function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] ptr);
    logic [PTR_W-1:0] res;
    if (ptr == PTR_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = ptr + PTR_W'(1);
    end
    return res;
  endfunction

endpackage

// ===== sv/dq_in_if.sv =====
// dq_in_if: command channel of the deque, valid/ready with command and value
// depends on dq_pkg

interface dq_in_if import dq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

// ===== sv/dq_out_if.sv =====
// dq_out_if: result channel of the deque, valid/ready with data, status, count and last
// depends on dq_pkg

interface dq_out_if import dq_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data;
  logic [STATUS_W-1:0]      status;
  logic [OCC_W-1:0]         occupancy_now;
  logic                     last;

  modport source (output valid, output data, output status, output occupancy_now,
                  output last, input ready);
  modport sink   (input valid, input data, input status, input occupancy_now,
                  input last, output ready);
endinterface

// ===== sv/double_ended_queue_top.sv =====
// Bounded deque of DEPTH signed 32-bit words held in a ring in one synchronous ram.
// A push, a refused push, or a pop or dump on an empty deque returns one beat.
// A pop returns one beat, read through the registered read port of the element store.
// A dump returns one beat per held element, front to rear, at one beat per cycle while the result
// channel takes them, paced by the single read port of the store; a new
// command is taken once the last beat of the previous one sits in the result register.
// Commands 5 to 7 are dropped without a result. No clearing pass is needed after reset.
// double_ended_queue_top: depends on dq_pkg, dq_in_if, dq_out_if, dq_ram and dq_ctrl

module double_ended_queue_top import dq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  dq_in_if.sink    cmd_ch,
  dq_out_if.source res_ch
);

  ram_req_t          ram_req;
  logic [DATA_W-1:0] ram_rdata;

  // controller
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .res_ch    (res_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  // element store
  dq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // reads and writes of the store never share a cycle
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_req.we && ram_req.re))
    else $error("store read and write in the same cycle");

  // a refused push only happens with the store full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.status == ST_FULL) |-> res_ch.occupancy_now == OCC_W'(DEPTH))
    else $error("full status with store not full");

  // an empty status is a single zero beat with a zero count
  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (res_ch.valid && res_ch.status == ST_EMPTY)
      |-> (res_ch.occupancy_now == '0 && res_ch.data == '0 && res_ch.last))
    else $error("malformed empty beat");

  // a write to the store always comes with an accepted command
  a_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    ram_req.we |-> (cmd_ch.valid && cmd_ch.ready))
    else $error("store write without an accepted command");

endmodule

// ===== sv/dq_ram.sv =====
// dq_ram: generic single-write, single-read synchronous ram with registered read
// no dependencies; read data holds while no read is issued

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/dq_ctrl.sv =====
// dq_ctrl: deque controller, keeps front pointer and count, sequences store accesses
// and owns the result register; depends on dq_pkg, dq_in_if and dq_out_if

module dq_ctrl import dq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dq_in_if.sink             cmd_ch,
  dq_out_if.source          res_ch,
  output ram_req_t          ram_req,
  input  logic [DATA_W-1:0] ram_rdata
);

  state_t state, state_next;
  logic [PTR_W-1:0] fp, fp_next;
  logic [CNT_W-1:0] occ, occ_next;
  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic [CNT_W-1:0] pend_idx, pend_idx_next;
  logic [CNT_W-1:0] n_total, n_total_next;
  logic             pend, pend_next;

  logic                ov, ov_next;
  logic [DATA_W-1:0]   od, od_next;
  logic [STATUS_W-1:0] ost, ost_next;
  logic [OCC_W-1:0]    oocc, oocc_next;
  logic                olast, olast_next;

  logic out_free;
  logic acc;
  logic ld;
  logic ld_last;
  logic issue;

  // result register drives the output channel
  assign res_ch.valid         = ov;
  assign res_ch.data          = od;
  assign res_ch.status        = ost;
  assign res_ch.occupancy_now = oocc;
  assign res_ch.last          = olast;

  assign out_free     = !ov || res_ch.ready;
  assign cmd_ch.ready = (state == S_IDLE) && out_free;
  assign acc          = cmd_ch.valid && cmd_ch.ready;

  // next state, store requests and result loading
  always_comb begin
    state_next    = state;
    fp_next       = fp;
    occ_next      = occ;
    rd_idx_next   = rd_idx;
    pend_idx_next = pend_idx;
    n_total_next  = n_total;
    pend_next     = pend;
    ram_req       = '0;
    ld            = 1'b0;
    ld_last       = 1'b0;
    issue         = 1'b0;
    od_next       = od;
    ost_next      = ost;
    oocc_next     = oocc;
    olast_next    = olast;

    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd_ch.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
              ld         = 1'b1;
              od_next    = '0;
              olast_next = 1'b1;
              if (occ >= CNT_W'(DEPTH)) begin
                ost_next  = ST_FULL;
                oocc_next = OCC_W'(occ);
              end else begin
                ram_req.we    = 1'b1;
                ram_req.wdata = cmd_ch.value;
                if (cmd_ch.cmd == CMD_PUSH_FRONT) begin
                  fp_next       = ring_dec(fp);
                  ram_req.waddr = ring_dec(fp);
                end else begin
                  ram_req.waddr = ring_add(fp, occ);
                end
                occ_next  = occ + CNT_W'(1);
                ost_next  = ST_OK;
                oocc_next = OCC_W'(occ + CNT_W'(1));
              end
            end
            CMD_POP_FRONT, CMD_POP_REAR, CMD_DUMP: begin
              if (occ == '0) begin
                ld         = 1'b1;
                od_next    = '0;
                ost_next   = ST_EMPTY;
                oocc_next  = OCC_W'(occ);
                olast_next = 1'b1;
              end else begin
                // first read goes out now, data lands next cycle
                ram_req.re    = 1'b1;
                pend_next     = 1'b1;
                pend_idx_next = '0;
                rd_idx_next   = CNT_W'(1);
                state_next    = S_DRAIN;
                if (cmd_ch.cmd == CMD_POP_FRONT) begin
                  ram_req.raddr = fp;
                  fp_next       = ring_inc(fp);
                  occ_next      = occ - CNT_W'(1);
                  n_total_next  = CNT_W'(1);
                end else if (cmd_ch.cmd == CMD_POP_REAR) begin
                  ram_req.raddr = ring_add(fp, occ - CNT_W'(1));
                  occ_next      = occ - CNT_W'(1);
                  n_total_next  = CNT_W'(1);
                end else begin
                  ram_req.raddr = fp;
                  n_total_next  = occ;
                end
              end
            end
            default: begin
              // unknown command: dropped with no result
            end
          endcase
        end
      end

      S_DRAIN: begin
        // move read data into the result register when it is free
        ld      = pend && out_free;
        ld_last = (pend_idx + CNT_W'(1)) == n_total;
        if (ld) begin
          od_next    = ram_rdata;
          ost_next   = ST_OK;
          oocc_next  = OCC_W'(occ);
          olast_next = ld_last;
        end
        // keep one read in flight while dumping
        issue = (rd_idx < n_total) && (!pend || ld);
        if (issue) begin
          ram_req.re    = 1'b1;
          ram_req.raddr = ring_add(fp, rd_idx);
          rd_idx_next   = rd_idx + CNT_W'(1);
          pend_idx_next = rd_idx;
          pend_next     = 1'b1;
        end else if (ld) begin
          pend_next = 1'b0;
        end
        if (ld && ld_last) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (ld) begin
      ov_next = 1'b1;
    end else if (res_ch.ready) begin
      ov_next = 1'b0;
    end else begin
      ov_next = ov;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fp    <= '0;
      occ   <= '0;
      pend  <= 1'b0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      fp    <= fp_next;
      occ   <= occ_next;
      pend  <= pend_next;
      ov    <= ov_next;
    end
  end

  // sequencing and result payload registers
  always_ff @(posedge clk) begin
    rd_idx   <= rd_idx_next;
    pend_idx <= pend_idx_next;
    n_total  <= n_total_next;
    od       <= od_next;
    ost      <= ost_next;
    oocc     <= oocc_next;
    olast    <= olast_next;
  end

endmodule
